[src/dfs_maze_carver_top_defines.svh]
// ----------------------------------------------------------------------------
// dfs_maze_carver_top_defines
// Assertion macros used by the maze carver walker (dmc_walker).
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_TOP_DEFINES_SVH
`define DFS_MAZE_CARVER_TOP_DEFINES_SVH

// same-cycle implication, on clk with arst_n
`define DMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, on clk with arst_n
`define DMC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, codes and the direction shuffle of the depth-first maze carver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	localparam int CRD_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [1:0] STATUS_CARVED = 2'd0;
	localparam logic [1:0] STATUS_STARTED = 2'd1;
	localparam logic [1:0] STATUS_DONE = 2'd2;
	localparam logic [1:0] STATUS_IDLE = 2'd3;

	localparam logic [1:0] DIR_ROW_UP = 2'd0;
	localparam logic [1:0] DIR_COL_UP = 2'd1;
	localparam logic [1:0] DIR_ROW_DOWN = 2'd2;
	localparam logic [1:0] DIR_COL_DOWN = 2'd3;

	typedef logic [CRD_W-1:0] crd_t;
	typedef logic [3:0][1:0] order_t;

	typedef struct packed {
		crd_t row;
		crd_t col;
		order_t order;
		logic [2:0] next;
	} frame_t;

	typedef struct packed {
		logic command;
		logic [5:0] start_col;
		logic [5:0] start_row;
		logic [1:0] pick_first;
		logic [1:0] pick_second;
		logic pick_third;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] wall_row;
		logic [7:0] wall_col;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
	} out_word_t;

	function automatic order_t shuffle(input logic [1:0] p0, input logic [1:0] p1,
		input logic p2);
		order_t o;
		logic [1:0] t;
		logic [1:0] j;
		o = {2'd3, 2'd2, 2'd1, 2'd0};
		j = p0;
		t = o[0];
		o[0] = o[j];
		o[j] = t;
		j = (p1 == 2'd3) ? 2'd1 : 2'(p1 + 2'd1);
		t = o[1];
		o[1] = o[j];
		o[j] = t;
		j = {1'b1, p2};
		t = o[2];
		o[2] = o[j];
		o[j] = t;
		return o;
	endfunction

endpackage

`default_nettype wire

[src/dmc_visit_map.sv]
// ----------------------------------------------------------------------------
// dmc_visit_map
// One-bit visited flag per cell, single port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_visit_map #(
	parameter int DEPTH = dmc_pkg::DEF_MAX_COLS * dmc_pkg::DEF_MAX_ROWS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     wdata,
	output logic                     rdata
);

	logic mem_q [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/dmc_walk_stack.sv]
// ----------------------------------------------------------------------------
// dmc_walk_stack
// Frames beneath the top of the walk, single port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_walk_stack #(
	parameter int DEPTH = dmc_pkg::DEF_MAX_COLS * dmc_pkg::DEF_MAX_ROWS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  dmc_pkg::frame_t          wdata,
	output dmc_pkg::frame_t          rdata
);

	dmc_pkg::frame_t mem_q [DEPTH];
	dmc_pkg::frame_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/dmc_walker.sv]
// ----------------------------------------------------------------------------
// dmc_walker
// Walk sequencer: map sweep, neighbour tests, push and pop of frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dfs_maze_carver_top_defines.svh"

module dmc_walker #(
	parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dmc_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output dmc_pkg::out_word_t out_word,
	input  dmc_pkg::crd_t     cols,
	input  dmc_pkg::crd_t     rows
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int DW = $clog2(CELLS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_VCHK = 3'd4;
	localparam logic [2:0] ST_POPW = 3'd5;

	logic [2:0] state_q;
	logic [DW-1:0] depth_q;
	logic walk_active_q;
	logic [AW-1:0] clr_q;
	dmc_pkg::in_word_t word_q;
	dmc_pkg::frame_t top_q;
	dmc_pkg::crd_t nb_row_q;
	dmc_pkg::crd_t nb_col_q;
	logic [7:0] wall_row_q;
	logic [7:0] wall_col_q;
	logic out_valid_q;
	dmc_pkg::out_word_t out_word_q;

	logic res_ok;
	logic in_take;
	logic place_go;
	logic finish_go;
	logic push_go;
	logic emit;
	logic [1:0] dir;
	logic [7:0] nb_r8;
	logic [7:0] nb_c8;
	logic [7:0] wr8;
	logic [7:0] wc8;
	logic in_grid;
	dmc_pkg::crd_t st_row;
	dmc_pkg::crd_t st_col;
	dmc_pkg::order_t new_order;

	logic vis_we;
	logic vis_re;
	logic vis_wdata;
	logic [AW-1:0] vis_addr;
	logic vis_rdata;
	logic stk_we;
	logic stk_re;
	logic [AW-1:0] stk_addr;
	dmc_pkg::frame_t stk_rdata;

	assign res_ok = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign new_order = dmc_pkg::shuffle(word_q.pick_first, word_q.pick_second,
		word_q.pick_third);

	assign st_row = ({1'b0, word_q.start_row} > (rows - 7'd1)) ? rows - 7'd1
		: {1'b0, word_q.start_row};
	assign st_col = ({1'b0, word_q.start_col} > (cols - 7'd1)) ? cols - 7'd1
		: {1'b0, word_q.start_col};

	assign place_go = (state_q == ST_PLACE) && res_ok;
	assign finish_go = (state_q == ST_STEP) && res_ok
		&& (!walk_active_q || (top_q.next[2] && depth_q == DW'(1)));
	assign push_go = (state_q == ST_VCHK) && !vis_rdata && res_ok;
	assign emit = place_go || finish_go || push_go;

	always_comb begin
		dir = top_q.order[top_q.next[1:0]];
		nb_r8 = {1'b0, top_q.row};
		nb_c8 = {1'b0, top_q.col};
		wr8 = {top_q.row, 1'b1};
		wc8 = {top_q.col, 1'b1};
		case (dir)
			dmc_pkg::DIR_ROW_UP: begin
				nb_r8 = nb_r8 + 8'd1;
				wr8 = wr8 + 8'd1;
			end
			dmc_pkg::DIR_COL_UP: begin
				nb_c8 = nb_c8 + 8'd1;
				wc8 = wc8 + 8'd1;
			end
			dmc_pkg::DIR_ROW_DOWN: begin
				nb_r8 = nb_r8 - 8'd1;
				wr8 = wr8 - 8'd1;
			end
			default: begin
				nb_c8 = nb_c8 - 8'd1;
				wc8 = wc8 - 8'd1;
			end
		endcase
		in_grid = (nb_r8 < {1'b0, rows}) && (nb_c8 < {1'b0, cols});
	end

	always_comb begin
		vis_we = 1'b0;
		vis_re = 1'b0;
		vis_wdata = 1'b0;
		vis_addr = clr_q;
		stk_we = 1'b0;
		stk_re = 1'b0;
		stk_addr = AW'(depth_q - DW'(1));
		case (state_q)
			ST_CLEAR: begin
				vis_we = 1'b1;
			end
			ST_PLACE: begin
				vis_we = res_ok;
				vis_wdata = 1'b1;
				vis_addr = AW'(st_row * MAX_COLS + st_col);
			end
			ST_STEP: begin
				vis_re = walk_active_q && !top_q.next[2] && in_grid;
				vis_addr = AW'(nb_r8[dmc_pkg::CRD_W-1:0] * MAX_COLS
					+ nb_c8[dmc_pkg::CRD_W-1:0]);
				stk_re = walk_active_q && top_q.next[2] && (depth_q != DW'(1));
				stk_addr = AW'(depth_q - DW'(2));
			end
			ST_VCHK: begin
				vis_we = !vis_rdata && res_ok;
				vis_wdata = 1'b1;
				vis_addr = AW'(nb_row_q * MAX_COLS + nb_col_q);
				stk_we = !vis_rdata && res_ok;
			end
			default: begin
			end
		endcase
	end

	dmc_visit_map #(
		.DEPTH(CELLS)
	) u_visit_map (
		.clk  (clk),
		.we   (vis_we),
		.re   (vis_re),
		.addr (vis_addr),
		.wdata(vis_wdata),
		.rdata(vis_rdata)
	);

	dmc_walk_stack #(
		.DEPTH(CELLS)
	) u_walk_stack (
		.clk  (clk),
		.we   (stk_we),
		.re   (stk_re),
		.addr (stk_addr),
		.wdata(top_q),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			walk_active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= (in_word.command == dmc_pkg::CMD_START) ? ST_CLEAR
							: ST_STEP;
					end
				end
				ST_CLEAR: begin
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (res_ok) begin
						depth_q <= DW'(1);
						walk_active_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (!walk_active_q || (top_q.next[2] && depth_q == DW'(1))) begin
						if (res_ok) begin
							if (walk_active_q) begin
								depth_q <= '0;
							end
							walk_active_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else if (top_q.next[2]) begin
						depth_q <= depth_q - DW'(1);
						state_q <= ST_POPW;
					end else if (in_grid) begin
						state_q <= ST_VCHK;
					end
				end
				ST_VCHK: begin
					if (vis_rdata) begin
						state_q <= ST_STEP;
					end else if (res_ok) begin
						depth_q <= depth_q + DW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_POPW: begin
					state_q <= ST_STEP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					word_q <= in_word;
					clr_q <= '0;
				end
			end
			ST_CLEAR: begin
				clr_q <= clr_q + AW'(1);
			end
			ST_PLACE: begin
				if (res_ok) begin
					top_q <= '{row: st_row, col: st_col, order: new_order, next: 3'd0};
					out_word_q <= '{status: dmc_pkg::STATUS_STARTED, wall_row: 8'd0,
						wall_col: 8'd0, cell_row: st_row[5:0], cell_col: st_col[5:0]};
				end
			end
			ST_STEP: begin
				if (!walk_active_q || (top_q.next[2] && depth_q == DW'(1))) begin
					if (res_ok) begin
						out_word_q <= '{status: walk_active_q ? dmc_pkg::STATUS_DONE
							: dmc_pkg::STATUS_IDLE, wall_row: 8'd0, wall_col: 8'd0,
							cell_row: 6'd0, cell_col: 6'd0};
					end
				end else if (!top_q.next[2]) begin
					top_q.next <= top_q.next + 3'd1;
					nb_row_q <= nb_r8[dmc_pkg::CRD_W-1:0];
					nb_col_q <= nb_c8[dmc_pkg::CRD_W-1:0];
					wall_row_q <= wr8;
					wall_col_q <= wc8;
				end
			end
			ST_VCHK: begin
				if (!vis_rdata && res_ok) begin
					top_q <= '{row: nb_row_q, col: nb_col_q, order: new_order,
						next: 3'd0};
					out_word_q <= '{status: dmc_pkg::STATUS_CARVED, wall_row: wall_row_q,
						wall_col: wall_col_q, cell_row: nb_row_q[5:0],
						cell_col: nb_col_q[5:0]};
				end
			end
			ST_POPW: begin
				top_q <= stk_rdata;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	`DMC_ASSERT_NOW(a_active_depth, walk_active_q, depth_q != '0, "active walk, empty stack")
	`DMC_ASSERT_NOW(a_pop_depth, state_q == ST_POPW, depth_q != '0, "pop with empty stack")
	`DMC_ASSERT_NXT(a_push_depth, push_go, depth_q == $past(depth_q) + DW'(1), "push lost")
	`DMC_ASSERT_NXT(a_place_walk, place_go, walk_active_q && depth_q == DW'(1), "start failed")

endmodule

`default_nettype wire

[src/dfs_maze_carver_top.sv]
// ----------------------------------------------------------------------------
// dfs_maze_carver_top
// Randomised depth-first maze carver: grid size registers and walk core.
// ----------------------------------------------------------------------------
// Start word: a sweep of the whole visited map, then the start cell is placed.
// Advance word: each direction is tried in turn; an in-grid neighbour is read from the
//   visited map and checked, and a spent frame is popped from the stack before the next try.
// One word in flight; the walker returns to idle as the result is raised, so the next
//   word can be taken also while that result waits on out_stall.
// Reset: grid 8 x 8, walk idle, stack empty; the map is swept by start.
`timescale 1ns / 1ps
`default_nettype none

module dfs_maze_carver_top #(
	parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dmc_pkg::in_word_t                  in_word,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dmc_pkg::out_word_t                 out_word,
	input  logic                               cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	dmc_pkg::crd_t grid_cols_q;
	dmc_pkg::crd_t grid_rows_q;
	dmc_pkg::crd_t cols;
	dmc_pkg::crd_t rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= 7'd8;
			grid_rows_q <= 7'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::REG_COLS: grid_cols_q <= cfg_data;
				dmc_pkg::REG_ROWS: grid_rows_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cols = (grid_cols_q == '0) ? 7'd1
		: ((grid_cols_q > MAX_COLS) ? dmc_pkg::CRD_W'(MAX_COLS) : grid_cols_q);
	assign rows = (grid_rows_q == '0) ? 7'd1
		: ((grid_rows_q > MAX_ROWS) ? dmc_pkg::CRD_W'(MAX_ROWS) : grid_rows_q);

	dmc_walker #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cols     (cols),
		.rows     (rows)
	);

endmodule

`default_nettype wire

[sim/tb_dfs_maze_carver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dfs_maze_carver_top
// Self-checking bench for the depth-first maze carver. A short scripted run
// covers idle advances, starts clamped to the grid, one-cell and full-size
// grids and a resize in mid-walk. Random phases follow, each with a new grid
// size, mostly complete or partial walks with random picks and some noise.
// Every accepted input word steps a behavioural carver model; every result
// word is compared field by field with the oldest expectation, scripted or predicted.
// ----------------------------------------------------------------------------

module tb_dfs_maze_carver_top;

	localparam int MAX_COLS = dmc_pkg::DEF_MAX_COLS;
	localparam int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS;
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int RANDOM_WORDS = 1000;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [5:0] row;
		logic [5:0] col;
		logic [3:0][1:0] order;
		logic [2:0] next;
	} walk_frame_t;

	typedef struct {
		bit has;
		dmc_pkg::out_word_t w;
	} typed_result_t;

	typedef enum logic {ROW_WORD, ROW_GRID} row_kind_t;

	typedef struct {
		row_kind_t kind;
		dmc_pkg::in_word_t w;
		bit has;
		dmc_pkg::out_word_t ew;
		logic [6:0] cols;
		logic [6:0] rows;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	dmc_pkg::in_word_t in_word;
	logic out_valid;
	logic out_stall = 1'b0;
	dmc_pkg::out_word_t out_word;
	logic cfg_we;
	logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [6:0] grid_cols = 7'd8;
	logic [6:0] grid_rows = 7'd8;
	bit visited [0:CELLS-1];
	walk_frame_t trail [0:CELLS-1];
	int depth = 0;
	bit walk_on = 1'b0;

	dmc_pkg::out_word_t walk_results[$];
	typed_result_t typed_results[$];
	script_row_t script[$];

	bit steady = 1'b0;
	int fails = 0;
	int cycles = 0;
	int n_words = 0;
	int n_started = 0;
	int n_carved = 0;
	int n_done = 0;
	int n_idle = 0;

	dfs_maze_carver_top #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int span(input logic [6:0] v, input int lim);
		if (v == 7'd0) return 1;
		if (int'(v) > lim) return lim;
		return int'(v);
	endfunction

	function automatic void enter_cell(input int r, input int c,
		input dmc_pkg::in_word_t w);
		walk_frame_t f;
		int picks [3];
		int i;
		int j;
		logic [1:0] t;
		picks[0] = int'(w.pick_first);
		picks[1] = int'(w.pick_second);
		picks[2] = int'(w.pick_third);
		for (i = 0; i < 4; i++) f.order[i] = 2'(i);
		for (i = 0; i < 3; i++) begin
			j = i + picks[i] % (4 - i);
			t = f.order[i];
			f.order[i] = f.order[j];
			f.order[j] = t;
		end
		f.row = 6'(r);
		f.col = 6'(c);
		f.next = 3'd0;
		visited[r * MAX_COLS + c] = 1'b1;
		if (depth < CELLS) begin
			trail[depth] = f;
			depth++;
		end
	endfunction

	function automatic dmc_pkg::out_word_t carve_step(input dmc_pkg::in_word_t w);
		dmc_pkg::out_word_t r;
		int cols;
		int rows;
		int sr;
		int sc;
		int dr;
		int dc;
		int nr;
		int nc;
		logic [1:0] dir;
		bit carved;
		r = '0;
		cols = span(grid_cols, MAX_COLS);
		rows = span(grid_rows, MAX_ROWS);
		if (w.command == dmc_pkg::CMD_START) begin
			sr = (int'(w.start_row) > rows - 1) ? rows - 1 : int'(w.start_row);
			sc = (int'(w.start_col) > cols - 1) ? cols - 1 : int'(w.start_col);
			foreach (visited[k]) visited[k] = 1'b0;
			depth = 0;
			enter_cell(sr, sc, w);
			walk_on = 1'b1;
			r.status = dmc_pkg::STATUS_STARTED;
			r.cell_row = 6'(sr);
			r.cell_col = 6'(sc);
		end else if (!walk_on) begin
			r.status = dmc_pkg::STATUS_IDLE;
		end else begin
			carved = 1'b0;
			while (depth > 0 && !carved) begin
				if (trail[depth-1].next >= 3'd4) begin
					depth--;
					continue;
				end
				dir = trail[depth-1].order[trail[depth-1].next[1:0]];
				trail[depth-1].next = trail[depth-1].next + 3'd1;
				dr = 0;
				dc = 0;
				case (dir)
					dmc_pkg::DIR_ROW_UP: dr = 1;
					dmc_pkg::DIR_COL_UP: dc = 1;
					dmc_pkg::DIR_ROW_DOWN: dr = -1;
					default: dc = -1;
				endcase
				nr = int'(trail[depth-1].row) + dr;
				nc = int'(trail[depth-1].col) + dc;
				if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
				if (visited[nr * MAX_COLS + nc]) continue;
				r.wall_row = 8'(2 * int'(trail[depth-1].row) + 1 + dr);
				r.wall_col = 8'(2 * int'(trail[depth-1].col) + 1 + dc);
				r.cell_row = 6'(nr);
				r.cell_col = 6'(nc);
				enter_cell(nr, nc, w);
				carved = 1'b1;
			end
			if (carved) begin
				r.status = dmc_pkg::STATUS_CARVED;
			end else begin
				r.status = dmc_pkg::STATUS_DONE;
				walk_on = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic check_word(input dmc_pkg::out_word_t e, input dmc_pkg::out_word_t a);
		if (a.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, a.status);
			fails++;
		end
		if (a.wall_row !== e.wall_row) begin
			$error("wall_row: expected %0d, got %0d", e.wall_row, a.wall_row);
			fails++;
		end
		if (a.wall_col !== e.wall_col) begin
			$error("wall_col: expected %0d, got %0d", e.wall_col, a.wall_col);
			fails++;
		end
		if (a.cell_row !== e.cell_row) begin
			$error("cell_row: expected %0d, got %0d", e.cell_row, a.cell_row);
			fails++;
		end
		if (a.cell_col !== e.cell_col) begin
			$error("cell_col: expected %0d, got %0d", e.cell_col, a.cell_col);
			fails++;
		end
	endtask

	always @(posedge clk) begin : monitor_b
		typed_result_t hint;
		dmc_pkg::out_word_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (walk_results.size() == 0) begin
					$error("result word %h with no expectation waiting", out_word);
					fails++;
				end else begin
					check_word(walk_results.pop_front(), out_word);
				end
			end
			if (in_valid && !in_stall) begin
				hint = typed_results.pop_front();
				pred = carve_step(in_word);
				walk_results.push_back(hint.has ? hint.w : pred);
				n_words++;
				case (pred.status)
					dmc_pkg::STATUS_CARVED: n_carved++;
					dmc_pkg::STATUS_STARTED: n_started++;
					dmc_pkg::STATUS_DONE: n_done++;
					default: n_idle++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 20);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic dmc_pkg::in_word_t word_of(input logic cmd, input int sc,
		input int sr, input int p0, input int p1, input int p2);
		dmc_pkg::in_word_t w;
		w.command = cmd;
		w.start_col = 6'(sc);
		w.start_row = 6'(sr);
		w.pick_first = 2'(p0);
		w.pick_second = 2'(p1);
		w.pick_third = 1'(p2);
		return w;
	endfunction

	function automatic dmc_pkg::out_word_t result_of(input logic [1:0] st, input int wr,
		input int wc, input int cr, input int cc);
		dmc_pkg::out_word_t r;
		r.status = st;
		r.wall_row = 8'(wr);
		r.wall_col = 8'(wc);
		r.cell_row = 6'(cr);
		r.cell_col = 6'(cc);
		return r;
	endfunction

	function automatic script_row_t row_word(input dmc_pkg::in_word_t w);
		script_row_t s;
		s.kind = ROW_WORD;
		s.w = w;
		s.has = 1'b0;
		s.ew = '0;
		s.cols = '0;
		s.rows = '0;
		return s;
	endfunction

	function automatic script_row_t row_typed(input dmc_pkg::in_word_t w,
		input dmc_pkg::out_word_t ew);
		script_row_t s;
		s = row_word(w);
		s.has = 1'b1;
		s.ew = ew;
		return s;
	endfunction

	function automatic script_row_t row_grid(input logic [6:0] c, input logic [6:0] r);
		script_row_t s;
		s = row_word('0);
		s.kind = ROW_GRID;
		s.cols = c;
		s.rows = r;
		return s;
	endfunction

	function automatic logic [6:0] pick_size();
		int k;
		k = $urandom_range(99);
		if (k < 6) return 7'($urandom_range(127));
		if (k < 10) begin
			case ($urandom_range(3))
				0: return 7'd0;
				1: return 7'd1;
				2: return 7'd64;
				default: return 7'd127;
			endcase
		end
		if (k < 22) return 7'($urandom_range(16, 7));
		return 7'($urandom_range(6, 1));
	endfunction

	task automatic send_word(input dmc_pkg::in_word_t w, input bit has,
		input dmc_pkg::out_word_t ew);
		typed_result_t hint;
		while (!steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		hint.has = has;
		hint.w = ew;
		typed_results.push_back(hint);
		in_word <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_walk_idle();
		in_valid <= 1'b0;
		while (walk_results.size() != 0 || typed_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_grid(input logic [6:0] c, input logic [6:0] r);
		cfg_we <= 1'b1;
		cfg_index <= dmc_pkg::REG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= dmc_pkg::REG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_cols = c;
		grid_rows = r;
	endtask

	initial begin : stimulus_b
		int sent;
		int ec;
		int er;
		int n_adv;
		sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		script.push_back(row_typed(word_of(dmc_pkg::CMD_ADVANCE, 63, 63, 3, 3, 1),
			result_of(dmc_pkg::STATUS_IDLE, 0, 0, 0, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_START, 0, 0, 0, 0, 0),
			result_of(dmc_pkg::STATUS_STARTED, 0, 0, 0, 0)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 3, 3, 1)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 21, 42, 1, 2, 0)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 42, 21, 2, 1, 1)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 0, 3, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_START, 63, 63, 3, 2, 1),
			result_of(dmc_pkg::STATUS_STARTED, 0, 0, 7, 7)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 3, 0, 1)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0)));
		script.push_back(row_grid(7'd0, 7'd0));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_START, 9, 5, 1, 1, 0),
			result_of(dmc_pkg::STATUS_STARTED, 0, 0, 0, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 2, 2, 1),
			result_of(dmc_pkg::STATUS_DONE, 0, 0, 0, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0),
			result_of(dmc_pkg::STATUS_IDLE, 0, 0, 0, 0)));
		script.push_back(row_grid(7'd127, 7'd127));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_START, 63, 63, 3, 3, 1),
			result_of(dmc_pkg::STATUS_STARTED, 0, 0, 63, 63)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 1, 0, 1)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 2, 3, 0)));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 3, 1, 1)));
		script.push_back(row_grid(7'd2, 7'd1));
		script.push_back(row_word(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 0, 2, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_START, 0, 0, 2, 0, 1),
			result_of(dmc_pkg::STATUS_STARTED, 0, 0, 0, 0)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 1, 3, 0),
			result_of(dmc_pkg::STATUS_CARVED, 1, 2, 0, 1)));
		script.push_back(row_typed(word_of(dmc_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1),
			result_of(dmc_pkg::STATUS_DONE, 0, 0, 0, 0)));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_GRID) begin
				wait_walk_idle();
				set_grid(script[i].cols, script[i].rows);
			end else begin
				send_word(script[i].w, script[i].has, script[i].ew);
			end
		end

		// each phase: drain, resize, then one to three walks, most run to completion
		while (sent < RANDOM_WORDS) begin
			wait_walk_idle();
			set_grid(pick_size(), pick_size());
			ec = span(grid_cols, MAX_COLS);
			er = span(grid_rows, MAX_ROWS);
			repeat ($urandom_range(3, 1)) begin
				steady = (sent >= 300 && sent < 450);
				if ($urandom_range(99) < 8) begin
					repeat ($urandom_range(3, 1)) begin
						send_word(word_of(1'($urandom_range(1)), $urandom_range(63),
							$urandom_range(63), $urandom_range(3), $urandom_range(3),
							$urandom_range(1)), 1'b0, '0);
						sent++;
					end
				end else begin
					send_word(word_of(dmc_pkg::CMD_START,
						($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(ec - 1),
						($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(er - 1),
						$urandom_range(3), $urandom_range(3), $urandom_range(1)), 1'b0, '0);
					sent++;
					n_adv = ec * er + $urandom_range(2);
					if (n_adv > 120) n_adv = $urandom_range(120, 20);
					if ($urandom_range(99) < 10) n_adv = $urandom_range(n_adv);
					repeat (n_adv) begin
						send_word(word_of(dmc_pkg::CMD_ADVANCE, $urandom_range(63),
							$urandom_range(63), $urandom_range(3), $urandom_range(3),
							$urandom_range(1)), 1'b0, '0);
						sent++;
					end
				end
			end
		end
		steady = 1'b0;

		wait_walk_idle();
		repeat (20) @(posedge clk);
		$display("%0d words over scripted and random grids: %0d starts, %0d walls carved,",
			n_words, n_started, n_carved);
		$display("%0d mazes completed, %0d advances while idle, %0d cycles", n_done, n_idle,
			cycles);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/dmc_pkg.sv
src/dmc_visit_map.sv
src/dmc_walk_stack.sv
src/dmc_walker.sv
src/dfs_maze_carver_top.sv
sim/tb_dfs_maze_carver_top.sv
